### sv/csvrt_pkg.sv
`timescale 1ns / 1ps
// csvrt_pkg: types, codes and sizing constants for the CSV row tokenizer.
// Used by every module of the block; depends on nothing.
package csvrt_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int ROW_BITS    = 16;
    // field index runs to MAX_COLUMNS-1, a field count to MAX_COLUMNS
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);

    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [2:0] {
        K_BYTE     = 3'd0,
        K_FIELD    = 3'd1,
        K_ROW      = 3'd2,
        K_MISMATCH = 3'd3,
        K_OVERFLOW = 3'd4,
        K_DONE     = 3'd5
    } kind_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] text_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [7:0]  column;
        logic [15:0] row;
        logic        is_header;
        logic [8:0]  found_count;
        logic [8:0]  expected_count;
        logic        failed;
        logic        last;
    } res_t;

    // one queue entry: the results caused by one input transaction
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } job_t;

endpackage

### sv/csv_row_tokenizer.sv
`timescale 1ns / 1ps
// csv_row_tokenizer: top level; front classifier, job queue and result back end.
// Depends on csvrt_pkg, csvrt_front, csvrt_queue, csvrt_back.
//
// Takes one byte (or end-of-data) per cycle and turns it into zero, one or two
// result transactions: field bytes, field ends, row ends, mismatch/overflow errors
// and done. Input takes one transaction per cycle as long as the two-entry job
// queue has room; output gives one result per cycle while res_stall is low, so
// only transactions that cause two results (a comma that overflows the column
// limit, end of data that closes an open line) take the output twice. A result
// reaches the output through a queue slot and the output register: the front is
// combinational and writes the job into the queue when the transaction is taken;
// the back loads it into the output register after earlier results. No clearing
// pass after reset; end of data returns all parse state to its reset value.
module csv_row_tokenizer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  csvrt_pkg::item_t item,
    output logic             res_valid,
    input  logic             res_stall,
    output csvrt_pkg::res_t  res
);
    import csvrt_pkg::*;

    logic acc;
    logic push;
    logic full;
    logic pop;
    logic head_valid;
    job_t job;
    job_t head;

    assign item_stall = full;
    assign acc        = item_valid && !item_stall;

    csvrt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .item  (item),
        .push  (push),
        .job   (job)
    );

    csvrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_job     (job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    csvrt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_stall  (res_stall)
    );

    // a mismatch report always carries two different counts
    a_mismatch_counts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == K_MISMATCH |-> res.found_count != res.expected_count)
        else $error("mismatch with equal counts");

    // the header line is always row zero
    a_header_row: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_header |-> res.row == '0)
        else $error("header result with nonzero row");

    // done ends the transaction's results and carries no column or header mark
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == K_DONE |-> res.last && res.column == '0 && !res.is_header)
        else $error("malformed done result");

    // a pushed job never lands in a full queue
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into full queue");

endmodule

### sv/csvrt_front.sv
`timescale 1ns / 1ps
// csvrt_front: per-byte parse state and classification; builds at most one job per transaction.
// Depends on csvrt_pkg.
module csvrt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            acc,
    input  csvrt_pkg::item_t item,
    output logic            push,
    output csvrt_pkg::job_t job
);
    import csvrt_pkg::*;

    logic                iq_reg, iq_next;
    logic                qp_reg, qp_next;
    logic                ls_reg, ls_next;
    logic                hs_reg, hs_next;
    logic [CNT_W-1:0]    hc_reg, hc_next;
    logic [CNT_W-1:0]    fi_reg, fi_next;
    logic [ROW_BITS-1:0] rc_reg, rc_next;
    logic                err_reg, err_next;

    logic [CNT_W-1:0]    count;
    logic                mism;
    logic                iq_eff;
    logic                has;
    logic [ROW_BITS-1:0] done_rc;
    logic                done_err;
    res_t                fin;
    res_t                dn;

    function automatic res_t mk(kind_t k, logic [7:0] b, logic [CNT_W-1:0] fi,
                                logic [ROW_BITS-1:0] rc, logic hs,
                                logic [CNT_W-1:0] fc, logic [CNT_W-1:0] ec);
        res_t r;
        r.kind           = k;
        r.out_byte       = b;
        r.column         = 8'(fi);
        r.row            = 16'(rc);
        r.is_header      = !hs;
        r.found_count    = 9'(fc);
        r.expected_count = 9'(ec);
        r.failed         = 1'b0;
        r.last           = 1'b0;
        return r;
    endfunction

    assign count = fi_reg + CNT_W'(1);
    assign mism  = hs_reg && (count != hc_reg);

    always_comb
    begin
        iq_next  = iq_reg;
        qp_next  = qp_reg;
        ls_next  = ls_reg;
        hs_next  = hs_reg;
        hc_next  = hc_reg;
        fi_next  = fi_reg;
        rc_next  = rc_reg;
        err_next = err_reg;
        job      = '0;
        has      = 1'b0;
        iq_eff   = iq_reg;
        done_rc  = rc_reg;
        done_err = err_reg;

        // line close: row end, or mismatch in its place
        fin = mk(mism ? K_MISMATCH : K_ROW, 8'h00, fi_reg, rc_reg, hs_reg,
                 mism ? count : '0, mism ? hc_reg : '0);

        if (item.cmd == CMD_END)
        begin
            has = 1'b1;
            if (!err_reg && ls_reg)
            begin
                job.two  = 1'b1;
                job.r0   = fin;
                done_rc  = mism ? rc_reg : rc_reg + ROW_BITS'(1);
                done_err = mism;
            end
            dn        = mk(K_DONE, 8'h00, '0, done_rc, 1'b1, '0, '0);
            dn.failed = done_err;
            if (job.two)
                job.r1 = dn;
            else
                job.r0 = dn;
            iq_next  = 1'b0;
            qp_next  = 1'b0;
            ls_next  = 1'b0;
            hs_next  = 1'b0;
            hc_next  = '0;
            fi_next  = '0;
            rc_next  = '0;
            err_next = 1'b0;
        end
        else
        begin
            dn = '0;
            if (!err_reg)
            begin
                if (item.text_byte == CH_NEWLINE)
                begin
                    if (ls_reg)
                    begin
                        has    = 1'b1;
                        job.r0 = fin;
                        if (!hs_reg)
                        begin
                            hc_next = count;
                            hs_next = 1'b1;
                        end
                        err_next = mism;
                        if (!mism)
                            rc_next = rc_reg + ROW_BITS'(1);
                        iq_next = 1'b0;
                        qp_next = 1'b0;
                        ls_next = 1'b0;
                        fi_next = '0;
                    end
                end
                else
                begin
                    ls_next = 1'b1;
                    if (qp_reg && item.text_byte == CH_QUOTE)
                    begin
                        // doubled quote inside quotes: one literal quote
                        qp_next = 1'b0;
                        has     = 1'b1;
                        job.r0  = mk(K_BYTE, CH_QUOTE, fi_reg, rc_reg, hs_reg, '0, '0);
                    end
                    else
                    begin
                        if (qp_reg)
                        begin
                            qp_next = 1'b0;
                            iq_eff  = 1'b0;
                            iq_next = 1'b0;
                        end
                        if (item.text_byte == CH_QUOTE)
                        begin
                            if (iq_eff)
                                qp_next = 1'b1;
                            else
                                iq_next = 1'b1;
                        end
                        else if (item.text_byte == CH_COMMA && !iq_eff)
                        begin
                            has    = 1'b1;
                            job.r0 = mk(K_FIELD, 8'h00, fi_reg, rc_reg, hs_reg, '0, '0);
                            if (count >= CNT_W'(MAX_COLUMNS))
                            begin
                                job.two  = 1'b1;
                                job.r1   = mk(K_OVERFLOW, 8'h00, fi_reg, rc_reg, hs_reg,
                                              '0, '0);
                                err_next = 1'b1;
                            end
                            else
                            begin
                                fi_next = count;
                            end
                        end
                        else
                        begin
                            has    = 1'b1;
                            job.r0 = mk(K_BYTE, item.text_byte, fi_reg, rc_reg, hs_reg,
                                        '0, '0);
                        end
                    end
                end
            end
        end
    end

    assign push = acc && has;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iq_reg  <= 1'b0;
            qp_reg  <= 1'b0;
            ls_reg  <= 1'b0;
            hs_reg  <= 1'b0;
            hc_reg  <= '0;
            fi_reg  <= '0;
            rc_reg  <= '0;
            err_reg <= 1'b0;
        end
        else if (acc)
        begin
            iq_reg  <= iq_next;
            qp_reg  <= qp_next;
            ls_reg  <= ls_next;
            hs_reg  <= hs_next;
            hc_reg  <= hc_next;
            fi_reg  <= fi_next;
            rc_reg  <= rc_next;
            err_reg <= err_next;
        end
    end

endmodule

### sv/csvrt_queue.sv
`timescale 1ns / 1ps
// csvrt_queue: short job queue between the front and back parts.
// Depends on csvrt_pkg.
module csvrt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csvrt_pkg::job_t wr_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output csvrt_pkg::job_t head
);
    import csvrt_pkg::*;

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

### sv/csvrt_back.sv
`timescale 1ns / 1ps
// csvrt_back: unpacks queued jobs into single results and drives the output register.
// Depends on csvrt_pkg.
module csvrt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  csvrt_pkg::job_t head,
    output logic            pop,
    output logic            res_valid,
    output csvrt_pkg::res_t res,
    input  logic            res_stall
);
    import csvrt_pkg::*;

    logic out_v_reg;
    logic sec_v_reg;
    res_t out_reg;
    res_t out_next;
    res_t sec_reg;
    logic load;

    assign load      = !out_v_reg || !res_stall;
    // the held second result goes out before the next job is taken
    assign pop       = load && !sec_v_reg && head_valid;
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    always_comb
    begin
        out_next = out_reg;
        if (sec_v_reg)
        begin
            out_next      = sec_reg;
            out_next.last = 1'b1;
        end
        else if (head_valid)
        begin
            out_next      = head.r0;
            out_next.last = !head.two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sec_v_reg <= 1'b0;
        end
        else if (load)
        begin
            out_v_reg <= sec_v_reg || head_valid;
            if (sec_v_reg)
                sec_v_reg <= 1'b0;
            else if (head_valid)
                sec_v_reg <= head.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
        if (pop)
            sec_reg <= head.r1;
    end

endmodule
